// ----- hw/rtl/bpc_pkg.sv -----
// ============================================================================
// bpc_pkg
// Shared types, constants and helpers for the barometric compensation unit.
// ============================================================================
package bpc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int DIV_STAGES  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFFS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LOW   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_MID   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_NINE  = 8'd3;

  localparam logic [63:0] HALF_SCALE_47 = 64'h0000_8000_0000_0000;
  localparam logic [63:0] PRESS_SCALE   = 64'd3125;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic [15:0] tc;
  } div_operands_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
    logic        neg;
    logic        fault;
    logic [15:0] tc;
  } div_stage_t;

  typedef struct packed {
    logic [63:0] quo;
    logic        fault;
    logic [15:0] tc;
  } div_result_t;

  function automatic logic [63:0] sext16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

endpackage

// ----- hw/rtl/bpc_mul64.sv -----
// ============================================================================
// bpc_mul64
// Two-stage 64 x 64 multiplier that keeps the low 64 bits of the product.
// ============================================================================
module bpc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(x[31:0]) * 64'(y[31:0]);
      lh <= 32'(x[31:0] * y[63:32]);
      hl <= 32'(x[63:32] * y[31:0]);
      p  <= ll + {lh + hl, 32'b0};
    end
  end

endmodule

// ----- hw/rtl/bpc_front.sv -----
// ============================================================================
// bpc_front
// Temperature compensation and the pressure numerator and divisor stages.
// ============================================================================
module bpc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  bpc_pkg::coeff_t        coeff,
  input  logic                   in_valid,
  input  logic [19:0]            temp_adc,
  input  logic [19:0]            press_adc,
  output logic                   out_valid,
  output bpc_pkg::div_operands_t out_ops
);

  logic [13:1] vld;

  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] m1;
  logic signed [33:0] dd;
  logic signed [22:0] v1_3;
  logic signed [22:0] v1_4;
  logic signed [21:0] q3;
  logic signed [37:0] m2;
  logic signed [25:0] fine;
  logic signed [28:0] t5;
  logic signed [20:0] tcs;
  logic [15:0]        tc_sat;
  logic signed [26:0] a6;
  logic signed [53:0] aa;
  logic signed [42:0] ap5;
  logic signed [42:0] ap2;
  logic signed [42:0] ap5_8;
  logic signed [42:0] ap2_8;
  logic signed [42:0] ap5_9;
  logic signed [42:0] ap2_9;
  logic [63:0]        pa;
  logic [63:0]        pb;
  logic [63:0]        b10;
  logic [63:0]        c10;
  logic [63:0]        n11;
  logic [63:0]        cp;
  logic [63:0]        np;
  logic [63:0]        c13;
  logic [20:0]        pr [1:10];
  logic [15:0]        tc [6:13];

  assign t5  = 29'(fine) * 29'sd5 + 29'sd128;
  assign tcs = t5[28:8];

  always_comb begin
    if (tcs > 21'sd32767) begin
      tc_sat = 16'h7fff;
    end else if (tcs < -21'sd32768) begin
      tc_sat = 16'h8000;
    end else begin
      tc_sat = tcs[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[12:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= $signed({1'b0, temp_adc[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
      d2    <= $signed({1'b0, temp_adc[19:4]}) - $signed({1'b0, coeff.t1});
      pr[1] <= 21'd1048576 - {1'b0, press_adc};
      for (int i = 2; i <= 10; i++) begin
        pr[i] <= pr[i-1];
      end
      m1    <= 34'(d1) * 34'($signed(coeff.t2));
      dd    <= 34'(d2) * 34'(d2);
      v1_3  <= m1[33:11];
      q3    <= dd[33:12];
      v1_4  <= v1_3;
      m2    <= 38'(q3) * 38'($signed(coeff.t3));
      fine  <= 26'(v1_4) + 26'($signed(m2[37:14]));
      tc[6] <= tc_sat;
      a6    <= 27'(fine) - 27'sd128000;
      for (int i = 7; i <= 13; i++) begin
        tc[i] <= tc[i-1];
      end
      aa    <= 54'(a6) * 54'(a6);
      ap5   <= 43'(a6) * 43'($signed(coeff.p5));
      ap2   <= 43'(a6) * 43'($signed(coeff.p2));
      ap5_8 <= ap5;
      ap2_8 <= ap2;
      ap5_9 <= ap5_8;
      ap2_9 <= ap2_8;
      b10   <= pa + (64'(ap5_9) << 17) + (bpc_pkg::sext16(coeff.p4) << 35);
      c10   <= {{8{pb[63]}}, pb[63:8]} + (64'(ap2_9) << 12) + bpc_pkg::HALF_SCALE_47;
      n11   <= {12'b0, pr[10], 31'b0} - b10;
      c13   <= {{33{cp[63]}}, cp[63:33]};
    end
  end

  bpc_mul64 u_mul_a (
    .clk (clk), .en (en), .x (64'(aa)), .y (bpc_pkg::sext16(coeff.p6)), .p (pa)
  );

  bpc_mul64 u_mul_b (
    .clk (clk), .en (en), .x (64'(aa)), .y (bpc_pkg::sext16(coeff.p3)), .p (pb)
  );

  bpc_mul64 u_mul_c (
    .clk (clk), .en (en), .x (c10), .y ({48'b0, coeff.p1}), .p (cp)
  );

  bpc_mul64 u_mul_d (
    .clk (clk), .en (en), .x (n11), .y (bpc_pkg::PRESS_SCALE), .p (np)
  );

  assign out_valid   = vld[13];
  assign out_ops.num = np;
  assign out_ops.den = c13;
  assign out_ops.tc  = tc[13];

endmodule

// ----- hw/rtl/bpc_divider.sv -----
// ============================================================================
// bpc_divider
// Pipelined signed 64-bit restoring divider, one quotient bit per stage.
// ============================================================================
module bpc_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  bpc_pkg::div_operands_t ops,
  output logic                   out_valid,
  output bpc_pkg::div_result_t   res
);

  bpc_pkg::div_stage_t st [0:bpc_pkg::DIV_STAGES];
  logic                vld [0:bpc_pkg::DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[bpc_pkg::DIV_STAGES+1] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      vld[bpc_pkg::DIV_STAGES+1] <= vld[bpc_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem   <= '0;
      st[0].num   <= ops.num[63] ? (64'd0 - ops.num) : ops.num;
      st[0].den   <= ops.den[63] ? (64'd0 - ops.den) : ops.den;
      st[0].neg   <= ops.num[63] ^ ops.den[63];
      st[0].fault <= (ops.den == 64'd0);
      st[0].tc    <= ops.tc;
      res.quo     <= st[bpc_pkg::DIV_STAGES].neg ? (64'd0 - st[bpc_pkg::DIV_STAGES].num)
                                                  : st[bpc_pkg::DIV_STAGES].num;
      res.fault   <= st[bpc_pkg::DIV_STAGES].fault;
      res.tc      <= st[bpc_pkg::DIV_STAGES].tc;
    end
  end

  for (genvar k = 0; k < bpc_pkg::DIV_STAGES; k++) begin : g_stage
    logic [63:0]         trial;
    logic                ge;
    bpc_pkg::div_stage_t nxt;

    always_comb begin
      trial     = {st[k].rem[62:0], st[k].num[63]};
      ge        = (trial >= st[k].den);
      nxt       = st[k];
      nxt.rem   = ge ? (trial - st[k].den) : trial;
      nxt.num   = {st[k].num[62:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[bpc_pkg::DIV_STAGES+1];

endmodule

// ----- hw/rtl/bpc_back.sv -----
// ============================================================================
// bpc_back
// Pressure refinement after the division and conversion to Q24.8.
// ============================================================================
module bpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bpc_pkg::coeff_t      coeff,
  input  logic                 in_valid,
  input  bpc_pkg::div_result_t div_res,
  output logic                 out_valid,
  output logic [15:0]          tc_out,
  output logic [31:0]          press_out,
  output logic                 fault_out
);

  logic [6:1]  vld;
  logic [63:0] q     [1:5];
  logic [15:0] tc    [1:5];
  logic        fault [1:5];
  logic [63:0] e1;
  logic [63:0] e2;
  logic [63:0] f;
  logic [63:0] f3;
  logic [63:0] f4;
  logic [63:0] sum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q[1]     <= div_res.quo;
      tc[1]    <= div_res.tc;
      fault[1] <= div_res.fault;
      for (int i = 2; i <= 5; i++) begin
        q[i]     <= q[i-1];
        tc[i]    <= tc[i-1];
        fault[i] <= fault[i-1];
      end
      f3        <= f;
      f4        <= f3;
      sum5      <= q[4] + {{25{e2[63]}}, e2[63:25]} + {{19{f4[63]}}, f4[63:19]};
      tc_out    <= tc[5];
      fault_out <= fault[5];
      press_out <= fault[5] ? 32'd0
                 : sum5[39:8] + {{12{coeff.p7[15]}}, coeff.p7, 4'b0};
    end
  end

  bpc_mul64 u_mul_e1 (
    .clk (clk), .en (en), .x (bpc_pkg::sext16(coeff.p9)),
    .y ({{13{div_res.quo[63]}}, div_res.quo[63:13]}), .p (e1)
  );

  bpc_mul64 u_mul_f (
    .clk (clk), .en (en), .x (bpc_pkg::sext16(coeff.p8)), .y (div_res.quo), .p (f)
  );

  bpc_mul64 u_mul_e2 (
    .clk (clk), .en (en), .x (e1), .y ({{13{q[2][63]}}, q[2][63:13]}), .p (e2)
  );

  assign out_valid = vld[6];

endmodule

// ----- hw/rtl/baro_temp_pressure_compensation_unit.sv -----
// ============================================================================
// baro_temp_pressure_compensation_unit
// Compensates raw temperature and pressure readings with calibration words.
// ============================================================================
//   Channel   Handshake                      Payload
//   sample    sample_valid / sample_stall    temp_adc, press_adc
//   result    result_valid / result_stall    temperature_centi, pressure_q24_8,
//                                            divide_fault
//   config    cfg_write                      cfg_index, cfg_data
//
// One transaction is accepted per cycle while sample_stall is low; a result passes
// through the 64 stages of the pipelined divider and the multiplier stages.
// Reset clears all valid bits and the calibration registers.
// A stalled result is held in the output register and a skid register; the
// pipeline halts only while the skid register is full.
module baro_temp_pressure_compensation_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [19:0]                     temp_adc,
  input  logic [19:0]                     press_adc,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [15:0]              temperature_centi,
  output logic [31:0]                     pressure_q24_8,
  output logic                            divide_fault
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_mid;
  logic [15:0] press_coeff_nine;

  bpc_pkg::coeff_t        coeff;
  bpc_pkg::div_operands_t ops;
  bpc_pkg::div_result_t   div_res;

  logic        en;
  logic        front_valid;
  logic        div_valid;
  logic        tail_valid;
  logic [15:0] tail_tc;
  logic [31:0] tail_press;
  logic        tail_fault;
  logic        skid_valid;
  logic [15:0] skid_tc;
  logic [31:0] skid_press;
  logic        skid_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_low <= '0;
      press_coeffs_mid <= '0;
      press_coeff_nine <= '0;
    end else if (cfg_write) begin
      if (cfg_index == bpc_pkg::REG_TEMP_COEFFS) begin
        temp_coeffs <= cfg_data[47:0];
      end
      if (cfg_index == bpc_pkg::REG_PRESS_LOW) begin
        press_coeffs_low <= cfg_data;
      end
      if (cfg_index == bpc_pkg::REG_PRESS_MID) begin
        press_coeffs_mid <= cfg_data;
      end
      if (cfg_index == bpc_pkg::REG_PRESS_NINE) begin
        press_coeff_nine <= cfg_data[15:0];
      end
    end
  end

  assign coeff.t1 = temp_coeffs[15:0];
  assign coeff.t2 = temp_coeffs[31:16];
  assign coeff.t3 = temp_coeffs[47:32];
  assign coeff.p1 = press_coeffs_low[15:0];
  assign coeff.p2 = press_coeffs_low[31:16];
  assign coeff.p3 = press_coeffs_low[47:32];
  assign coeff.p4 = press_coeffs_low[63:48];
  assign coeff.p5 = press_coeffs_mid[15:0];
  assign coeff.p6 = press_coeffs_mid[31:16];
  assign coeff.p7 = press_coeffs_mid[47:32];
  assign coeff.p8 = press_coeffs_mid[63:48];
  assign coeff.p9 = press_coeff_nine;

  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  bpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .coeff        (coeff),
    .in_valid     (sample_valid),
    .temp_adc     (temp_adc),
    .press_adc    (press_adc),
    .out_valid    (front_valid),
    .out_ops      (ops)
  );

  bpc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .ops       (ops),
    .out_valid (div_valid),
    .res       (div_res)
  );

  bpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .coeff     (coeff),
    .in_valid  (div_valid),
    .div_res   (div_res),
    .out_valid (tail_valid),
    .tc_out    (tail_tc),
    .press_out (tail_press),
    .fault_out (tail_fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (!result_stall) begin
          skid_valid <= 1'b0;
        end
      end else if (tail_valid) begin
        if (!result_valid || !result_stall) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!result_stall) begin
        temperature_centi <= skid_tc;
        pressure_q24_8    <= skid_press;
        divide_fault      <= skid_fault;
      end
    end else if (tail_valid) begin
      if (!result_valid || !result_stall) begin
        temperature_centi <= tail_tc;
        pressure_q24_8    <= tail_press;
        divide_fault      <= tail_fault;
      end else begin
        skid_tc    <= tail_tc;
        skid_press <= tail_press;
        skid_fault <= tail_fault;
      end
    end
  end

endmodule

// ----- hw/rtl/bpc_checker.sv -----
// ============================================================================
// bpc_checker
// Port-level checks for the barometric compensation unit.
// ============================================================================
module bpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] temperature_centi,
  input logic [31:0] pressure_q24_8,
  input logic        divide_fault
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("Reset did not clear the output side.");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("Input stalled with no result pending.");

  a_stall_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(result_valid && result_stall))
    else $error("Input stall rose without a stalled result.");

  a_fault_zero_press: assert property (@(posedge clk) disable iff (rst)
    result_valid && divide_fault |-> pressure_q24_8 == 32'd0)
    else $error("Divide fault with nonzero pressure.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temperature_centi)
      && $stable(pressure_q24_8) && $stable(divide_fault))
    else $error("Stalled result transaction changed.");

endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk               (clk),
  .rst               (rst),
  .sample_valid      (sample_valid),
  .sample_stall      (sample_stall),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .temperature_centi (temperature_centi),
  .pressure_q24_8    (pressure_q24_8),
  .divide_fault      (divide_fault)
);

// ----- dv/baro_temp_pressure_compensation_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Compensation result checker
// Watches the configuration port and both channels of the compensation unit,
// predicts each compensated reading in 64-bit fixed point and compares it
// field by field with the result the unit returns.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  logic [19:0]                     temp_adc,
  input  logic [19:0]                     press_adc,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic signed [15:0]              temperature_centi,
  input  logic [31:0]                     pressure_q24_8,
  input  logic                            divide_fault,
  output int                              fail_count,
  output int                              outstanding,
  output int                              readings_checked,
  output int                              faults_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic               fault;
  } reading_t;

  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_mid;
  logic [15:0] press_cal_nine;
  reading_t    pending_readings[$];

  function automatic logic [63:0] asr(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] widen(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic reading_t compensate(input logic [19:0] tr, input logic [19:0] pr);
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] d1, d2, fine, tc, a, b, c, p, e, f, num, mn, mc, q;
    reading_t r;
    t1 = {48'd0, temp_cal[15:0]};
    t2 = widen(temp_cal[31:16]);
    t3 = widen(temp_cal[47:32]);
    p1 = {48'd0, press_cal_low[15:0]};
    p2 = widen(press_cal_low[31:16]);
    p3 = widen(press_cal_low[47:32]);
    p4 = widen(press_cal_low[63:48]);
    p5 = widen(press_cal_mid[15:0]);
    p6 = widen(press_cal_mid[31:16]);
    p7 = widen(press_cal_mid[47:32]);
    p8 = widen(press_cal_mid[63:48]);
    p9 = widen(press_cal_nine);

    d1 = {44'd0, tr} >> 3;
    d1 = d1 - (t1 << 1);
    d2 = ({44'd0, tr} >> 4) - t1;
    fine = asr(d1 * t2, 11) + asr(asr(d2 * d2, 12) * t3, 14);
    tc = asr(fine * 64'd5 + 64'd128, 8);
    if ($signed(tc) < -64'sd32768) tc = -64'sd32768;
    else if ($signed(tc) > 64'sd32767) tc = 64'sd32767;
    r.temp = tc[15:0];

    a = fine - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    c = asr(a * a * p3, 8) + ((a * p2) << 12);
    c = c + (64'd1 << 47);
    c = asr(c * p1, 33);
    if (c == 64'd0) begin
      r.press = '0;
      r.fault = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, pr};
      num = ((p << 31) - b) * 64'd3125;
      mn = num[63] ? -num : num;
      mc = c[63] ? -c : c;
      q = mn / mc;
      p = (num[63] != c[63]) ? -q : q;
      e = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      f = asr(p8 * p, 19);
      p = asr(p + e + f, 8) + (p7 << 4);
      r.press = p[31:0];
      r.fault = 1'b0;
    end
    return r;
  endfunction

  assign outstanding = pending_readings.size();

  always @(posedge clk) begin
    reading_t want;
    int errs;
    errs = 0;
    if (rst) begin
      temp_cal <= '0;
      press_cal_low <= '0;
      press_cal_mid <= '0;
      press_cal_nine <= '0;
      pending_readings.delete();
      fail_count <= 0;
      readings_checked <= 0;
      faults_seen <= 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        pending_readings.push_back(compensate(temp_adc, press_adc));
      end
      if (cfg_write) begin
        case (cfg_index)
          bpc_pkg::REG_TEMP_COEFFS: temp_cal <= cfg_data[47:0];
          bpc_pkg::REG_PRESS_LOW:   press_cal_low <= cfg_data;
          bpc_pkg::REG_PRESS_MID:   press_cal_mid <= cfg_data;
          bpc_pkg::REG_PRESS_NINE:  press_cal_nine <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        readings_checked <= readings_checked + 1;
        if (divide_fault) faults_seen <= faults_seen + 1;
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected result transaction temp %0d press %h fault %b",
                   $time, temperature_centi, pressure_q24_8, divide_fault);
          errs = errs + 1;
        end else begin
          want = pending_readings.pop_front();
          if (temperature_centi !== want.temp) begin
            $display("%0t: temperature_centi expected %0d actual %0d",
                     $time, want.temp, temperature_centi);
            errs = errs + 1;
          end
          if (pressure_q24_8 !== want.press) begin
            $display("%0t: pressure_q24_8 expected %h actual %h",
                     $time, want.press, pressure_q24_8);
            errs = errs + 1;
          end
          if (divide_fault !== want.fault) begin
            $display("%0t: divide_fault expected %b actual %b",
                     $time, want.fault, divide_fault);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- dv/baro_temp_pressure_compensation_unit_test.sv -----
// ----------------------------------------------------------------------------
// Compensation unit testbench
// Loads several calibration sets, from reset values through typical sensor
// words to the extremes, and streams directed and random raw readings through
// the unit with random idling on both channels.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            sample_valid;
  logic                            sample_stall;
  logic [19:0]                     temp_adc;
  logic [19:0]                     press_adc;
  logic                            result_valid;
  logic                            result_stall;
  logic signed [15:0]              temperature_centi;
  logic [31:0]                     pressure_q24_8;
  logic                            divide_fault;
  int                              fail_count;
  int                              outstanding;
  int                              readings_checked;
  int                              faults_seen;
  logic                            steady;
  int unsigned                     spare_pick;

  baro_temp_pressure_compensation_unit DUT (.*);

  baro_temp_pressure_compensation_unit_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= steady ? 1'b0 : ($urandom_range(99) < 22);
  end

  task automatic push_reading(input logic [19:0] tr, input logic [19:0] pr);
    while (!steady && $urandom_range(99) < 22) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    temp_adc <= tr;
    press_adc <= pr;
    forever begin
      @(negedge clk);
      if (!sample_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle;
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                          input logic [63:0] pm, input logic [15:0] p9);
    write_reg(bpc_pkg::REG_TEMP_COEFFS, {16'd0, tc});
    write_reg(bpc_pkg::REG_PRESS_LOW, pl);
    write_reg(bpc_pkg::REG_PRESS_MID, pm);
    write_reg(bpc_pkg::REG_PRESS_NINE, {48'd0, p9});
  endtask

  task automatic run_readings(input int count);
    push_reading(20'd0, 20'd0);
    push_reading(20'hFFFFF, 20'hFFFFF);
    push_reading(20'd0, 20'hFFFFF);
    push_reading(20'hFFFFF, 20'd0);
    push_reading(20'd519888, 20'd415148);
    push_reading(20'h80000, 20'h80000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 60)
        push_reading(20'($urandom_range(600000, 400000)),
                     20'($urandom_range(500000, 250000)));
      else
        push_reading(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 1'b0;
    temp_adc = '0;
    press_adc = '0;
    result_stall = 1'b0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: every divisor is zero.
    run_readings(60);
    settle();

    // Typical sensor calibration.
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    run_readings(180);
    steady = 1'b1;
    run_readings(120);
    steady = 1'b0;
    settle();

    // All ones, then the signed extremes.
    load_cal('1, '1, '1, '1);
    run_readings(80);
    settle();
    load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
             {4{16'h7FFF}}, 16'h8000);
    run_readings(80);
    settle();
    load_cal({16'h7FFF, 16'h8000, 16'h0000}, {4{16'h7FFF}},
             {4{16'h8000}}, 16'h7FFF);
    run_readings(60);
    settle();

    // Random calibration words, with writes to unused indexes between them.
    for (int k = 0; k < 6; k++) begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
               {$urandom, $urandom}, 16'($urandom));
      spare_pick = $urandom_range(255, 4);
      write_reg(spare_pick[bpc_pkg::CFG_INDEX_W-1:0], {$urandom, $urandom});
      run_readings(45);
      settle();
    end

    $display("Checked %0d compensated readings over 11 calibration sets, %0d divide faults.",
             readings_checked, faults_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d readings outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- baro_temp_pressure_compensation_unit.f -----
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_mul64.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_divider.sv
hw/rtl/bpc_back.sv
hw/rtl/baro_temp_pressure_compensation_unit.sv
hw/rtl/bpc_checker.sv
dv/baro_temp_pressure_compensation_unit_checker.sv
dv/baro_temp_pressure_compensation_unit_test.sv
